[hdl/wrrps_pkg.sv]
// ----------------------------------------------------------------------------
// wrrps_pkg
// Shared widths, register addresses and types of the weighted round robin
// path scheduler.
// ----------------------------------------------------------------------------
package wrrps_pkg;

    localparam int LEN_W      = 16;
    localparam int MSS_W      = 16;
    localparam int MASK_W     = 4;
    localparam int WEIGHT_W   = 8;
    localparam int QUOTA_W    = 8;
    localparam int LIMIT_W    = 24;
    localparam int CHOSEN_W   = 2;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 32;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int DIV_CNT_W  = 5;
    localparam int MUL_CNT_W  = 3;
    localparam int SEGS_W     = LEN_W + 1;

    localparam logic [QUOTA_W-1:0]  QUOTA_MAX      = 8'hFF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_DEFAULT = 8'd1;
    localparam logic [MSS_W-1:0]    MSS_MIN        = 16'd1;

    localparam logic [APB_ADDR_W-1:0] ADDR_WEIGHT_ONE   = 4'h0;
    localparam logic [APB_ADDR_W-1:0] ADDR_WEIGHT_TWO   = 4'h4;
    localparam logic [APB_ADDR_W-1:0] ADDR_NEEDS_WINDOW = 4'h8;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight_path_one;
        logic [WEIGHT_W-1:0] weight_path_two;
        logic                reset_needs_window;
    } cfg_t;

endpackage

[hdl/wrrps_cfg.sv]
// ----------------------------------------------------------------------------
// wrrps_cfg
// APB register file: path weights and round reset mode.
// ----------------------------------------------------------------------------
module wrrps_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wrrps_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [wrrps_pkg::APB_DATA_W-1:0] pwdata,
    output logic [wrrps_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    output wrrps_pkg::cfg_t                  cfg
);

    wrrps_pkg::cfg_t cfg_reg;
    wrrps_pkg::cfg_t cfg_next;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr)
                wrrps_pkg::ADDR_WEIGHT_ONE:
                    cfg_next.weight_path_one = pwdata[wrrps_pkg::WEIGHT_W-1:0];
                wrrps_pkg::ADDR_WEIGHT_TWO:
                    cfg_next.weight_path_two = pwdata[wrrps_pkg::WEIGHT_W-1:0];
                wrrps_pkg::ADDR_NEEDS_WINDOW:
                    cfg_next.reset_needs_window = pwdata[0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            wrrps_pkg::ADDR_WEIGHT_ONE:
                prdata = wrrps_pkg::APB_DATA_W'(cfg_reg.weight_path_one);
            wrrps_pkg::ADDR_WEIGHT_TWO:
                prdata = wrrps_pkg::APB_DATA_W'(cfg_reg.weight_path_two);
            wrrps_pkg::ADDR_NEEDS_WINDOW:
                prdata = wrrps_pkg::APB_DATA_W'(cfg_reg.reset_needs_window);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.weight_path_one    <= '0;
            cfg_reg.weight_path_two    <= '0;
            cfg_reg.reset_needs_window <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[hdl/wrrps_div.sv]
// ----------------------------------------------------------------------------
// wrrps_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wrrps_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [wrrps_pkg::LEN_W-1:0] dividend,
    input  logic [wrrps_pkg::MSS_W-1:0] divisor,
    output logic                        busy,
    output logic [wrrps_pkg::LEN_W-1:0] quotient,
    output logic                        rem_nz
);

    logic [wrrps_pkg::MSS_W-1:0]     rem_reg,  rem_next;
    logic [wrrps_pkg::LEN_W-1:0]     quot_reg, quot_next;
    logic [wrrps_pkg::DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic                            busy_reg, busy_next;
    logic [wrrps_pkg::MSS_W:0]       trial;
    logic [wrrps_pkg::MSS_W:0]       diff;
    logic                            fits;

    assign trial    = {rem_reg, quot_reg[wrrps_pkg::LEN_W-1]};
    assign diff     = trial - {1'b0, divisor};
    assign fits     = ~diff[wrrps_pkg::MSS_W];
    assign busy     = busy_reg;
    assign quotient = quot_reg;
    assign rem_nz   = |rem_reg;

    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            quot_next = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[wrrps_pkg::MSS_W-1:0] : trial[wrrps_pkg::MSS_W-1:0];
            quot_next = {quot_reg[wrrps_pkg::LEN_W-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == wrrps_pkg::DIV_CNT_W'(wrrps_pkg::LEN_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

endmodule

[hdl/wrrps_mul.sv]
// ----------------------------------------------------------------------------
// wrrps_mul
// Bit-serial shift-add multiplier: remaining segments times mss.
// ----------------------------------------------------------------------------
module wrrps_mul (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [wrrps_pkg::WEIGHT_W-1:0] multiplier,
    input  logic [wrrps_pkg::MSS_W-1:0]    multiplicand,
    output logic                           busy,
    output logic [wrrps_pkg::LIMIT_W-1:0]  product
);

    logic [wrrps_pkg::LIMIT_W-1:0]   acc_reg,    acc_next;
    logic [wrrps_pkg::LIMIT_W-1:0]   mcand_reg,  mcand_next;
    logic [wrrps_pkg::WEIGHT_W-1:0]  mplier_reg, mplier_next;
    logic [wrrps_pkg::MUL_CNT_W-1:0] cnt_reg,    cnt_next;
    logic                            busy_reg,   busy_next;

    assign busy    = busy_reg;
    assign product = acc_reg;

    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        if (start) begin
            acc_next    = '0;
            mcand_next  = wrrps_pkg::LIMIT_W'(multiplicand);
            mplier_next = multiplier;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[wrrps_pkg::LIMIT_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[wrrps_pkg::WEIGHT_W-1:1]};
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == wrrps_pkg::MUL_CNT_W'(wrrps_pkg::WEIGHT_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

endmodule

[hdl/weighted_round_robin_path_sched.sv]
// Flow: an accepted word is scanned (a second scan follows a round restart);
// when a path is granted, the serial divider and multiplier run, the quota is
// updated and the result word loads; when nothing is granted the scan goes
// straight to the output load. One word at a time: the next word is taken
// the cycle after the result loads; a stalled output delays that load.
// Reset: aresetn synchronous, active low; clears all quotas and control state.
// ----------------------------------------------------------------------------
// weighted_round_robin_path_sched
// Weighted round robin choice of a transmit path per segment, with per-path
// quotas, one round restart and a serial byte limit computation.
// ----------------------------------------------------------------------------
module weighted_round_robin_path_sched #(
    parameter int NUM_PATHS = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // segment_bytes[15:0], current_mss[31:16], present_mask[35:32],
    // ready_full_mask[39:36], ready_basic_mask[43:40], zero pad
    input  logic [wrrps_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // granted[0], chosen_path[2:1], byte_limit[26:3], round_restarted[27],
    // zero pad
    output logic [wrrps_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wrrps_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [wrrps_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [wrrps_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);

    localparam int PICK_W  = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
    localparam int STATE_W = 3;

    localparam logic [STATE_W-1:0] ST_IDLE = 3'd0;
    localparam logic [STATE_W-1:0] ST_SCAN = 3'd1;
    localparam logic [STATE_W-1:0] ST_CALC = 3'd2;
    localparam logic [STATE_W-1:0] ST_FIN  = 3'd3;

    wrrps_pkg::cfg_t cfg;

    logic [STATE_W-1:0]             state_reg,   state_next;
    logic [wrrps_pkg::LEN_W-1:0]    len_reg,     len_next;
    logic [wrrps_pkg::MSS_W-1:0]    mss_reg,     mss_next;
    logic [wrrps_pkg::MASK_W-1:0]   pres_reg,    pres_next;
    logic [wrrps_pkg::MASK_W-1:0]   rfull_reg,   rfull_next;
    logic [wrrps_pkg::MASK_W-1:0]   rbasic_reg,  rbasic_next;
    logic                           pass_reg,    pass_next;
    logic                           have_reg,    have_next;
    logic [PICK_W-1:0]              pick_reg,    pick_next;
    logic [wrrps_pkg::WEIGHT_W-1:0] split_reg,   split_next;
    logic                           grant_reg,   grant_next;
    logic                           restart_reg, restart_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [wrrps_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [wrrps_pkg::QUOTA_W-1:0]  quota_reg  [NUM_PATHS];
    logic [wrrps_pkg::QUOTA_W-1:0]  quota_next [NUM_PATHS];

    logic [NUM_PATHS+wrrps_pkg::MASK_W-1:0] pres_pad, rfull_pad, clr_pad;
    logic [NUM_PATHS-1:0]           pres_ext, rfull_ext, clr_ext;
    logic [wrrps_pkg::MASK_W-1:0]   clr_sel;

    logic                           scan_found, scan_any, scan_full;
    logic [PICK_W-1:0]              scan_pick;
    logic [wrrps_pkg::WEIGHT_W-1:0] scan_split;
    logic [wrrps_pkg::WEIGHT_W-1:0] slot_w;
    logic [wrrps_pkg::QUOTA_W-1:0]  slot_q;
    logic                           restart;
    logic                           eff_have;
    logic [PICK_W-1:0]              eff_pick;
    logic [wrrps_pkg::WEIGHT_W-1:0] eff_split;
    logic                           grant_ok;

    logic                           unit_start;
    logic                           div_busy, mul_busy, div_rem_nz;
    logic [wrrps_pkg::LEN_W-1:0]    div_quot;
    logic [wrrps_pkg::LIMIT_W-1:0]  mul_prod;
    logic [wrrps_pkg::SEGS_W-1:0]   segs;
    logic [wrrps_pkg::SEGS_W-1:0]   quota_sum;
    logic [wrrps_pkg::QUOTA_W-1:0]  quota_sat;
    logic                           s_accept;

    wrrps_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wrrps_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (unit_start),
        .dividend (len_reg),
        .divisor  (mss_reg),
        .busy     (div_busy),
        .quotient (div_quot),
        .rem_nz   (div_rem_nz)
    );

    wrrps_mul u_mul (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (unit_start),
        .multiplier   (eff_split),
        .multiplicand (mss_reg),
        .busy         (mul_busy),
        .product      (mul_prod)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid & s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign clr_sel   = cfg.reset_needs_window ? rfull_reg : rbasic_reg;
    assign pres_pad  = {{NUM_PATHS{1'b0}}, pres_reg};
    assign rfull_pad = {{NUM_PATHS{1'b0}}, rfull_reg};
    assign clr_pad   = {{NUM_PATHS{1'b0}}, pres_reg & clr_sel};
    assign pres_ext  = pres_pad[NUM_PATHS-1:0];
    assign rfull_ext = rfull_pad[NUM_PATHS-1:0];
    assign clr_ext   = clr_pad[NUM_PATHS-1:0];

    always_comb begin
        scan_found = 1'b0;
        scan_any   = 1'b0;
        scan_full  = 1'b1;
        scan_pick  = '0;
        scan_split = '0;
        slot_w     = '0;
        slot_q     = '0;
        for (int i = 0; i < NUM_PATHS; i++) begin
            if (pres_ext[i] && !scan_found) begin
                slot_q = quota_reg[i];
                if (i == 0) begin
                    slot_w = cfg.weight_path_one;
                end else if (i == 1) begin
                    slot_w = cfg.weight_path_two;
                end else begin
                    slot_w = wrrps_pkg::WEIGHT_DEFAULT;
                end
                if (slot_q != '0 && slot_q < slot_w) begin
                    scan_found = 1'b1;
                    scan_any   = 1'b1;
                    scan_pick  = PICK_W'(i);
                    scan_split = slot_w - slot_q;
                end else if (slot_q == '0) begin
                    scan_any   = 1'b1;
                    scan_pick  = PICK_W'(i);
                    scan_split = slot_w;
                end
                if (slot_q < slot_w) begin
                    scan_full = 1'b0;
                end
            end
        end
    end

    assign restart   = !pass_reg && !scan_found && (|pres_ext) && scan_full;
    assign eff_have  = scan_any | have_reg;
    assign eff_pick  = scan_any ? scan_pick : pick_reg;
    assign eff_split = scan_any ? scan_split : split_reg;
    assign grant_ok  = eff_have && rfull_ext[eff_pick];

    assign segs      = (len_reg > mss_reg)
                     ? ({1'b0, div_quot} + wrrps_pkg::SEGS_W'(div_rem_nz))
                     : wrrps_pkg::SEGS_W'(1);
    assign quota_sum = wrrps_pkg::SEGS_W'(quota_reg[pick_reg]) + segs;
    assign quota_sat = (quota_sum > wrrps_pkg::SEGS_W'(wrrps_pkg::QUOTA_MAX))
                     ? wrrps_pkg::QUOTA_MAX : quota_sum[wrrps_pkg::QUOTA_W-1:0];

    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        mss_next      = mss_reg;
        pres_next     = pres_reg;
        rfull_next    = rfull_reg;
        rbasic_next   = rbasic_reg;
        pass_next     = pass_reg;
        have_next     = have_reg;
        pick_next     = pick_reg;
        split_next    = split_reg;
        grant_next    = grant_reg;
        restart_next  = restart_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        quota_next    = quota_reg;
        unit_start    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    len_next     = s_tdata[15:0];
                    mss_next     = (s_tdata[31:16] == '0) ? wrrps_pkg::MSS_MIN
                                                         : s_tdata[31:16];
                    pres_next    = s_tdata[35:32];
                    rfull_next   = s_tdata[39:36];
                    rbasic_next  = s_tdata[43:40];
                    pass_next    = 1'b0;
                    have_next    = 1'b0;
                    grant_next   = 1'b0;
                    restart_next = 1'b0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                have_next  = eff_have;
                pick_next  = eff_pick;
                split_next = eff_split;
                if (restart) begin
                    for (int i = 0; i < NUM_PATHS; i++) begin
                        if (clr_ext[i]) begin
                            quota_next[i] = '0;
                        end
                    end
                    restart_next = 1'b1;
                    pass_next    = 1'b1;
                end else if (grant_ok) begin
                    grant_next = 1'b1;
                    unit_start = 1'b1;
                    state_next = ST_CALC;
                end else begin
                    grant_next = 1'b0;
                    state_next = ST_FIN;
                end
            end
            ST_CALC: begin
                if (!div_busy && !mul_busy) begin
                    quota_next[pick_reg] = quota_sat;
                    state_next           = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = '0;
                    m_tdata_next[0]    = grant_reg;
                    m_tdata_next[2:1]  = grant_reg ? wrrps_pkg::CHOSEN_W'(pick_reg) : '0;
                    m_tdata_next[26:3] = grant_reg ? mul_prod : '0;
                    m_tdata_next[27]   = restart_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pass_reg     <= 1'b0;
            have_reg     <= 1'b0;
            grant_reg    <= 1'b0;
            restart_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_PATHS; i++) begin
                quota_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            pass_reg     <= pass_next;
            have_reg     <= have_next;
            grant_reg    <= grant_next;
            restart_reg  <= restart_next;
            m_tvalid_reg <= m_tvalid_next;
            quota_reg    <= quota_next;
        end
        len_reg     <= len_next;
        mss_reg     <= mss_next;
        pres_reg    <= pres_next;
        rfull_reg   <= rfull_next;
        rbasic_reg  <= rbasic_next;
        pick_reg    <= pick_next;
        split_reg   <= split_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

[hdl/wrrps_chk.sv]
// ----------------------------------------------------------------------------
// wrrps_chk
// Port-level checks of the path scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module wrrps_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [wrrps_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_no_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[26:1] == '0)
        else $error("path or byte limit set without a grant");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while one is in work");

    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared one cycle after accept");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[wrrps_pkg::M_TDATA_W-1:28] == '0)
        else $error("pad bits of result word not zero");

endmodule

bind weighted_round_robin_path_sched wrrps_chk u_wrrps_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

[test/weighted_round_robin_path_sched_tb.sv]
// ----------------------------------------------------------------------------
// weighted_round_robin_path_sched_tb
// Self-checking bench for the weighted round robin path scheduler. Segment
// requests go in on the input stream and register settings over APB. A
// behavioral model of the per-path quotas predicts each result word, which
// is compared field by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module weighted_round_robin_path_sched_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = 4;
    localparam int CLK_HALF     = 5;
    localparam int MAX_WAIT     = 12;
    localparam int DRAIN_CYCLES = 30;

    typedef struct {
        logic [wrrps_pkg::LEN_W-1:0]  seg_bytes;
        logic [wrrps_pkg::MSS_W-1:0]  mss;
        logic [wrrps_pkg::MASK_W-1:0] present;
        logic [wrrps_pkg::MASK_W-1:0] ready_full;
        logic [wrrps_pkg::MASK_W-1:0] ready_basic;
    } segment_req_t;

    typedef struct {
        logic                           granted;
        logic [wrrps_pkg::CHOSEN_W-1:0] path;
        logic [wrrps_pkg::LIMIT_W-1:0]  byte_limit;
        logic                           restarted;
    } path_grant_t;

    logic                              aclk    = 1'b0;
    logic                              aresetn = 1'b0;
    // segment_bytes, current_mss, present_mask, ready_full_mask,
    // ready_basic_mask, zero pad
    logic [wrrps_pkg::S_TDATA_W-1:0]   s_tdata  = '0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    // granted, chosen_path, byte_limit, round_restarted, zero pad
    logic [wrrps_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                              m_tvalid;
    logic                              m_tready = 1'b1;
    logic                              psel     = 1'b0;
    logic                              penable  = 1'b0;
    logic                              pwrite   = 1'b0;
    logic [wrrps_pkg::APB_ADDR_W-1:0]  paddr    = '0;
    logic [wrrps_pkg::APB_DATA_W-1:0]  pwdata   = '0;
    logic [wrrps_pkg::APB_DATA_W-1:0]  prdata;
    logic                              pready;

    logic [wrrps_pkg::QUOTA_W-1:0]  quota_model [SLOTS];
    logic [wrrps_pkg::WEIGHT_W-1:0] weight_one;
    logic [wrrps_pkg::WEIGHT_W-1:0] weight_two;
    logic                           needs_window;

    path_grant_t pending_grants[$];
    bit          no_idle;
    int          ready_hold;
    int          mismatch_count;
    int          requests_sent;
    int          results_checked;
    int          grants_seen;
    int          restarts_seen;
    int          settings_used;

    weighted_round_robin_path_sched #(
        .NUM_PATHS(SLOTS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int path_weight(int slot);
        if (slot == 0) begin
            return weight_one;
        end
        if (slot == 1) begin
            return weight_two;
        end
        return wrrps_pkg::WEIGHT_DEFAULT;
    endfunction

    function automatic path_grant_t predict_schedule(segment_req_t r);
        int unsigned                  mss_eff;
        int unsigned                  segs;
        int unsigned                  new_quota;
        int unsigned                  split;
        int unsigned                  pick;
        int                           seen;
        int                           full;
        bit                           have;
        bit                           found;
        bit                           done;
        bit                           restarted;
        logic [wrrps_pkg::MASK_W-1:0] clr;
        path_grant_t                  res;
        mss_eff   = (r.mss == 0) ? 1 : r.mss;
        have      = 1'b0;
        pick      = 0;
        split     = 1;
        restarted = 1'b0;
        done      = 1'b0;
        for (int pass = 0; pass < 2; pass++) begin
            if (!done) begin
                seen  = 0;
                full  = 0;
                found = 1'b0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!found && r.present[i]) begin
                        seen++;
                        if (quota_model[i] > 0 && quota_model[i] < path_weight(i)) begin
                            split = path_weight(i) - quota_model[i];
                            pick  = i;
                            have  = 1'b1;
                            found = 1'b1;
                        end else begin
                            if (quota_model[i] == 0) begin
                                split = path_weight(i);
                                pick  = i;
                                have  = 1'b1;
                            end
                            if (quota_model[i] >= path_weight(i)) begin
                                full++;
                            end
                        end
                    end
                end
                if (found || seen == 0 || seen != full || pass == 1) begin
                    done = 1'b1;
                end else begin
                    clr = r.present & (needs_window ? r.ready_full : r.ready_basic);
                    for (int i = 0; i < SLOTS; i++) begin
                        if (clr[i]) begin
                            quota_model[i] = '0;
                        end
                    end
                    restarted = 1'b1;
                end
            end
        end
        res.granted    = 1'b0;
        res.path       = '0;
        res.byte_limit = '0;
        res.restarted  = restarted;
        if (have && r.ready_full[pick]) begin
            segs = (r.seg_bytes > mss_eff) ? (r.seg_bytes + mss_eff - 1) / mss_eff : 1;
            new_quota = quota_model[pick] + segs;
            if (new_quota > wrrps_pkg::QUOTA_MAX) begin
                new_quota = wrrps_pkg::QUOTA_MAX;
            end
            quota_model[pick] = new_quota[wrrps_pkg::QUOTA_W-1:0];
            res.granted    = 1'b1;
            res.path       = pick[wrrps_pkg::CHOSEN_W-1:0];
            res.byte_limit = wrrps_pkg::LIMIT_W'(split * mss_eff);
        end
        return res;
    endfunction

    function automatic segment_req_t make_req(int len, int mss,
                                              logic [wrrps_pkg::MASK_W-1:0] present,
                                              logic [wrrps_pkg::MASK_W-1:0] full,
                                              logic [wrrps_pkg::MASK_W-1:0] basic);
        segment_req_t r;
        r.seg_bytes   = len[wrrps_pkg::LEN_W-1:0];
        r.mss         = mss[wrrps_pkg::MSS_W-1:0];
        r.present     = present;
        r.ready_full  = full;
        r.ready_basic = basic;
        return r;
    endfunction

    function automatic segment_req_t random_req();
        segment_req_t r;
        int           kind;
        int           mss;
        int           len;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            mss = $urandom_range(1, 65535);
            len = $urandom_range(1, mss);
        end else if (kind < 90) begin
            mss = $urandom_range(1, 8192);
            len = $urandom_range(1, 8 * mss);
            if (len > 65535) begin
                len = 65535;
            end
        end else begin
            mss = (kind < 93) ? 0 : $urandom_range(0, 15);
            len = $urandom_range(0, 65535);
            if (kind >= 97) begin
                mss = $urandom_range(0, 65535);
            end
        end
        r.seg_bytes = len[wrrps_pkg::LEN_W-1:0];
        r.mss       = mss[wrrps_pkg::MSS_W-1:0];
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            r.present = '1;
        end else if (kind < 90) begin
            r.present = wrrps_pkg::MASK_W'($urandom_range(1, 15));
        end else begin
            r.present = wrrps_pkg::MASK_W'($urandom_range(0, 15));
        end
        kind = $urandom_range(0, 99);
        r.ready_full  = (kind < 80) ? r.present : wrrps_pkg::MASK_W'($urandom_range(0, 15));
        r.ready_basic = r.ready_full | wrrps_pkg::MASK_W'($urandom_range(0, 15));
        if ($urandom_range(0, 9) == 0) begin
            r.ready_basic = wrrps_pkg::MASK_W'($urandom_range(0, 15));
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got_val, int want_val);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got_val,
                 want_val);
    endtask

    task automatic write_register(logic [wrrps_pkg::APB_ADDR_W-1:0] addr,
                                  logic [wrrps_pkg::APB_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            wrrps_pkg::ADDR_WEIGHT_ONE: begin
                weight_one = value[wrrps_pkg::WEIGHT_W-1:0];
            end
            wrrps_pkg::ADDR_WEIGHT_TWO: begin
                weight_two = value[wrrps_pkg::WEIGHT_W-1:0];
            end
            wrrps_pkg::ADDR_NEEDS_WINDOW: begin
                needs_window = value[0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic set_weights(int w_one, int w_two, bit window);
        write_register(wrrps_pkg::ADDR_WEIGHT_ONE, wrrps_pkg::APB_DATA_W'(w_one));
        write_register(wrrps_pkg::ADDR_WEIGHT_TWO, wrrps_pkg::APB_DATA_W'(w_two));
        write_register(wrrps_pkg::ADDR_NEEDS_WINDOW, wrrps_pkg::APB_DATA_W'(window));
        settings_used++;
    endtask

    task automatic send_segment(segment_req_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= wrrps_pkg::S_TDATA_W'({r.ready_basic, r.ready_full, r.present, r.mss,
                                           r.seg_bytes});
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_grants.push_back(predict_schedule(r));
        requests_sent++;
    endtask

    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        while (pending_grants.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Result words: check against the oldest prediction, then draw the next stall.
    always @(posedge aclk) begin : result_check
        path_grant_t got;
        path_grant_t want;
        int          stall;
        if (aresetn && m_tvalid && m_tready) begin
            got.granted    = m_tdata[0];
            got.path       = m_tdata[2:1];
            got.byte_limit = m_tdata[26:3];
            got.restarted  = m_tdata[27];
            if (pending_grants.size() == 0) begin
                report_mismatch("word with no pending request", 1, 0);
            end else begin
                want = pending_grants.pop_front();
                results_checked++;
                grants_seen   += want.granted;
                restarts_seen += want.restarted;
                if (got.granted !== want.granted) begin
                    report_mismatch("granted", got.granted, want.granted);
                end
                if (got.path !== want.path) begin
                    report_mismatch("chosen_path", got.path, want.path);
                end
                if (got.byte_limit !== want.byte_limit) begin
                    report_mismatch("byte_limit", got.byte_limit, want.byte_limit);
                end
                if (got.restarted !== want.restarted) begin
                    report_mismatch("round_restarted", got.restarted, want.restarted);
                end
            end
            stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            m_tready   <= (stall == 0);
            ready_hold <= stall;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_tready   <= (ready_hold == 1);
        end
    end

    task automatic test_reset_weights();
        send_segment(make_req(100, 1000, 4'h0, 4'hF, 4'hF));
        send_segment(make_req(1, 1, 4'hF, 4'hF, 4'hF));
        send_segment(make_req(0, 0, 4'hF, 4'hF, 4'hF));
        send_segment(make_req(65535, 65535, 4'h3, 4'h3, 4'h3));
        send_segment(make_req(500, 100, 4'h1, 4'h0, 4'h1));
        send_segment(make_req(500, 100, 4'h3, 4'h3, 4'h0));
        wait_for_idle();
    endtask

    task automatic test_directed_corners();
        set_weights(2, 3, 1'b1);
        send_segment(make_req(65535, 1, 4'h1, 4'h1, 4'h1));
        send_segment(make_req(65535, 65535, 4'h2, 4'h2, 4'h2));
        send_segment(make_req(1, 0, 4'hF, 4'hF, 4'hF));
        send_segment(make_req(3000, 1000, 4'hF, 4'hF, 4'hF));
        send_segment(make_req(1, 65535, 4'hF, 4'h0, 4'hF));
        send_segment(make_req(1, 65535, 4'hC, 4'h8, 4'h4));
        send_segment(make_req(1, 65535, 4'hC, 4'hC, 4'hC));
        send_segment(make_req(1, 65535, 4'hC, 4'h0, 4'hC));
        wait_for_idle();
        set_weights(255, 255, 1'b0);
        send_segment(make_req(65535, 1, 4'h3, 4'h3, 4'h3));
        send_segment(make_req(65535, 1, 4'h3, 4'h3, 4'h3));
        send_segment(make_req(1, 65535, 4'h3, 4'h0, 4'h1));
        send_segment(make_req(1, 65535, 4'h3, 4'h3, 4'h2));
        send_segment(make_req(65535, 1, 4'hF, 4'hF, 4'h0));
        send_segment(make_req(2, 1, 4'hF, 4'hF, 4'hF));
        wait_for_idle();
    endtask

    task automatic test_weighted_rounds(int w_one, int w_two, bit window, int count);
        set_weights(w_one, w_two, window);
        for (int n = 0; n < count; n++) begin
            no_idle = ((n / 40) % 4 == 3);
            send_segment(random_req());
        end
        no_idle = 1'b0;
        wait_for_idle();
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            quota_model[i] = '0;
        end
        weight_one   = '0;
        weight_two   = '0;
        needs_window = 1'b1;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_weights();
        test_directed_corners();
        test_weighted_rounds(1, 1, 1'b0, 250);
        test_weighted_rounds(255, 255, 1'b1, 250);
        test_weighted_rounds(3, 5, 1'b1, 300);
        test_weighted_rounds(0, 7, 1'b0, 250);
        test_weighted_rounds(255, 0, 1'b0, 250);
        test_weighted_rounds(2, 1, 1'b1, 250);
        test_weighted_rounds($urandom_range(0, 255), $urandom_range(0, 255),
                             1'($urandom_range(0, 1)), 250);
        $display("Sent %0d segment requests under %0d weight settings, checked %0d words.",
                 requests_sent, settings_used, results_checked);
        $display("Grants: %0d, round restarts: %0d, mismatches: %0d.", grants_seen,
                 restarts_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
